@@ sv/qmsg_pkg.sv @@
// qmsg_pkg: shared types and constants for the queued step generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qmsg_pkg;
  localparam int AXES = 3;
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_KILL  = 2'd3;
  localparam logic CFG_TPU = 1'b0;
  localparam logic CFG_POL = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [31:0] dur;
  } item_t;

  typedef struct packed {
    logic [2:0] step_pulse;
    logic [2:0] direction;
    logic [2:0] driver_enable;
    logic [2:0] active_mask;
    logic       queue_full;
    logic       move_accepted;
    logic [1:0] queue_level;
  } result_t;
endpackage
`default_nettype wire

@@ sv/qmsg_div.sv @@
// qmsg_div: 64/32 restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module qmsg_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic             busy,
  output logic [63:0] quo
);
  logic [32:0] rem;
  logic [63:0] n;
  logic [6:0]  cnt;
  logic [32:0] sh;
  logic [31:0] d;
  always_comb sh = {rem[31:0], n[63]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      n <= num;
      d <= den;
    end else if (busy) begin
      n <= {n[62:0], 1'b0};
      if (sh >= {1'b0, d}) begin
        rem <= sh - {1'b0, d};
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= sh;
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ sv/qmsg_front.sv @@
// qmsg_front: input skid queue that decouples accepted words from the back end.
// Depends on qmsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qmsg_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire qmsg_pkg::item_t in_item,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output qmsg_pkg::item_t      q_item
);
  qmsg_pkg::item_t mem [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic       push;
  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_item = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

@@ sv/qmsg_back.sv @@
// qmsg_back: move ring, axis timers and move loader with a shared divider.
// Depends on qmsg_pkg and qmsg_div.
`timescale 1ns / 1ps
`default_nettype none
module qmsg_back #(
  parameter int QUEUE_DEPTH  = 4,
  parameter int PERIOD_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      tpu,
  input  wire logic [2:0]      pol,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire qmsg_pkg::item_t q_item,
  output logic                 r_valid,
  input  wire logic            r_ready,
  output qmsg_pkg::result_t    r_data
);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = 33 - PERIOD_WIDTH;
  localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {S_RUN, S_LD, S_DIV, S_NORM, S_FIN} st_t;
  st_t st;

  logic [127:0] ring [QUEUE_DEPTH];
  logic [127:0] cur;
  logic [QW-1:0] head, tail;
  logic [31:0] steps [3];
  logic [SW-1:0] ps_rl [3];
  logic [SW-1:0] ps_left [3];
  logic [PERIOD_WIDTH-1:0] per_rl [3];
  logic [PERIOD_WIDTH-1:0] per_cnt [3];
  logic [2:0] act, dirb, enb;
  logic [1:0] ax;
  logic [63:0] total;
  logic [31:0] mag;
  logic [31:0] per;
  logic [SW-1:0] scale;
  logic d_start, d_busy;
  logic [63:0] d_quo;
  logic        res_acc;

  function automatic logic [QW-1:0] nxt(input logic [QW-1:0] i);
    return (i == QLAST) ? '0 : i + QW'(1);
  endfunction

  qmsg_div u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(total), .den(mag),
    .busy(d_busy), .quo(d_quo)
  );

  logic [31:0] raw;
  logic [QW-1:0] lvl;
  always_comb begin
    unique case (ax)
      2'd0: raw = cur[31:0];
      2'd1: raw = cur[63:32];
      default: raw = cur[95:64];
    endcase
    lvl = (head >= tail) ? head - tail : QW'(QUEUE_DEPTH) - tail + head;
  end

  assign q_pop = (st == S_RUN) && q_valid && !r_valid;

  always_ff @(posedge clk) begin
    logic [2:0] a, pul;
    logic [QW-1:0] h, t;
    logic nz;
    logic acc;
    if (rst) begin
      st <= S_RUN;
      head <= '0;
      tail <= '0;
      act <= '0;
      dirb <= '0;
      enb <= '0;
      r_valid <= 1'b0;
      ax <= '0;
      d_start <= 1'b0;
    end else begin
      d_start <= (st == S_LD) && (raw != 32'd0);
      if (r_valid && r_ready) r_valid <= 1'b0;
      unique case (st)
        S_RUN: if (q_pop) begin
          a = act; pul = '0; h = head; t = tail; nz = 1'b0; acc = 1'b0;
          unique case (q_item.mode)
            qmsg_pkg::MODE_TICK: begin
              for (int i = 0; i < 3; i++) begin
                if (act[i]) begin
                  if ({1'b0, per_cnt[i]} + 1 >= {1'b0, per_rl[i]}) begin
                    per_cnt[i] <= '0;
                    if (ps_left[i] > SW'(1)) ps_left[i] <= ps_left[i] - SW'(1);
                    else begin
                      ps_left[i] <= ps_rl[i];
                      pul[i] = 1'b1;
                      if (steps[i] > 32'd0) steps[i] <= steps[i] - 32'd1;
                      if (steps[i] <= 32'd1) a[i] = 1'b0;
                    end
                  end else per_cnt[i] <= per_cnt[i] + PERIOD_WIDTH'(1);
                end
              end
              enb <= enb & ~(act & ~a);
            end
            qmsg_pkg::MODE_MOVE: begin
              nz = (q_item.mx | q_item.my | q_item.mz) != 32'd0;
              if (nz && nxt(head) != tail) begin
                ring[head] <= {q_item.dur, q_item.mz, q_item.my, q_item.mx};
                h = nxt(head);
                acc = 1'b1;
              end
            end
            qmsg_pkg::MODE_FLUSH: t = head;
            default: begin
              t = head;
              a = '0;
            end
          endcase
          res_acc <= acc;
          act <= a;
          head <= h;
          tail <= t;
          r_data.step_pulse <= pul;
          if (a == '0 && h != t) st <= S_LD;
          else begin
            st <= S_FIN;
          end
          cur <= (h != head) ? {q_item.dur, q_item.mz, q_item.my, q_item.mx} : ring[t];
          ax <= '0;
        end
        S_LD: begin
          total <= {24'd0, cur[127:96] * 40'(tpu)};
          mag <= raw[31] ? 32'd0 - raw : raw;
          dirb[ax] <= raw[31] ^ pol[ax];
          if (raw != 32'd0) st <= S_DIV;
          else if (ax == 2'd2) begin
            tail <= nxt(tail);
            st <= S_FIN;
          end else ax <= ax + 2'd1;
        end
        S_DIV: if (!d_busy && !d_start) begin
          per <= (d_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : d_quo[31:0];
          scale <= SW'(1);
          st <= S_NORM;
        end
        S_NORM: begin
          if ((per >> PERIOD_WIDTH) != 32'd0) begin
            per <= per >> 1;
            scale <= scale << 1;
          end else begin
            steps[ax] <= mag;
            ps_rl[ax] <= scale;
            ps_left[ax] <= scale;
            per_rl[ax] <= (per == 32'd0) ? PERIOD_WIDTH'(1) : per[PERIOD_WIDTH-1:0];
            per_cnt[ax] <= '0;
            act[ax] <= 1'b1;
            enb[ax] <= 1'b1;
            if (ax == 2'd2) begin
              tail <= nxt(tail);
              st <= S_FIN;
            end else begin
              ax <= ax + 2'd1;
              st <= S_LD;
            end
          end
        end
        default: begin
          r_data.direction <= dirb;
          r_data.driver_enable <= enb;
          r_data.active_mask <= act;
          r_data.queue_full <= nxt(head) == tail;
          r_data.move_accepted <= res_acc;
          r_data.queue_level <= 2'(lvl);
          r_valid <= 1'b1;
          st <= S_RUN;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/queued_multi_axis_step_generator_core.sv @@
// Top level of the queued three-axis step generator.
// Depends on qmsg_pkg, qmsg_front, qmsg_back.
//  channel | dir | handshake              | content
//  s_axis  | in  | s_axis_tvalid/tready   | mode, moves, duration
//  m_axis  | out | m_axis_tvalid/tready   | step, dir, enable, status
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
// A tick, flush, kill or stored move passes through S_RUN and S_FIN in the back end.
// A move load then steps through S_LD for each axis; a moving axis also runs
// the bit-serial divider in S_DIV and the period normalize loop in S_NORM
// (up to 16 shifts with the default PERIOD_WIDTH).
// Reset is synchronous; a 2-word input queue absorbs output stalls.
`timescale 1ns / 1ps
`default_nettype none
module queued_multi_axis_step_generator_core #(
  parameter int QUEUE_DEPTH  = 4,
  parameter int PERIOD_WIDTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] mode, [33:2] move_x, [65:34] move_y, [97:66] move_z, [129:98] duration_us
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [2:0] step_pulse, [5:3] direction, [8:6] driver_enable, [11:9] active_mask,
  // [12] queue_full, [13] move_accepted, [15:14] queue_level
  output logic [15:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);
  logic [7:0] tpu;
  logic [2:0] pol;
  qmsg_pkg::item_t in_item, q_item;
  qmsg_pkg::result_t r;
  logic q_valid, q_pop;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tpu <= 8'd32;
      pol <= 3'd0;
    end else if (cfg_valid) begin
      if (cfg_index == qmsg_pkg::CFG_TPU) tpu <= cfg_data;
      else pol <= cfg_data[2:0];
    end
  end

  assign in_item = '{mode: s_axis_tdata[1:0], mx: s_axis_tdata[33:2],
                     my: s_axis_tdata[65:34], mz: s_axis_tdata[97:66],
                     dur: s_axis_tdata[129:98]};

  qmsg_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  qmsg_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .PERIOD_WIDTH(PERIOD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .tpu(tpu), .pol(pol), .q_valid(q_valid), .q_pop(q_pop),
    .q_item(q_item), .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(r)
  );

  assign m_axis_tdata = {r.queue_level, r.move_accepted, r.queue_full, r.active_mask,
                         r.driver_enable, r.direction, r.step_pulse};
endmodule
`default_nettype wire

@@ sv/qmsg_checker.sv @@
// qmsg_checker: port-level assertions, bound to the top level.
// Depends on queued_multi_axis_step_generator_core.
`timescale 1ns / 1ps
`default_nettype none
module qmsg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_en: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:9] & ~m_axis_tdata[8:6]) == 3'd0)
    else $error("active axis without driver enable");
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[12] |-> !m_axis_tdata[13] || m_axis_tdata[15:14] != 2'd0)
    else $error("full flag inconsistent");
endmodule

bind queued_multi_axis_step_generator_core qmsg_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ test/queued_multi_axis_step_generator_core_tb.sv @@
// Self-checking bench for queued_multi_axis_step_generator_core: random and directed
// tick/move/flush/kill words, with the expected status computed in-bench.
// Depends on qmsg_pkg and the core RTL.
`timescale 1ns / 1ps
module queued_multi_axis_step_generator_core_tb;

  localparam int LIMIT  = 20000;
  localparam int SETTLE = 300;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = 1'b0;
  logic [7:0]   cfg_data = '0;

  always #2 clk = ~clk;

  queued_multi_axis_step_generator_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // motion state mirror
  logic [31:0] slot_mem [4][4];
  int unsigned wr_ptr, rd_ptr;
  logic [31:0] steps_rem [3];
  logic [16:0] scale_reload [3];
  logic [16:0] scale_left [3];
  logic [15:0] per_reload [3];
  logic [15:0] per_cnt [3];
  logic [2:0]  act_bits, dir_bits, en_bits;
  logic [7:0]  tpu;
  logic [2:0]  pol;

  qmsg_pkg::item_t   pending_words [$];
  qmsg_pkg::result_t status_expected [$];
  int      errors = 0;
  logic    calm = 1'b0;
  logic    stall_req = 1'b0;

  function automatic int unsigned ring_nx(int unsigned i);
    return (i + 1 >= 4) ? 0 : i + 1;
  endfunction

  function automatic qmsg_pkg::result_t motion_step(qmsg_pkg::item_t it);
    qmsg_pkg::result_t r;
    logic [2:0]  pulses;
    logic        acc;
    logic [63:0] tot, per;
    logic [31:0] raw, mag;
    logic [16:0] scale;
    logic        neg;
    pulses = '0;
    acc = 1'b0;
    if (it.mode == qmsg_pkg::MODE_TICK) begin
      for (int a = 0; a < 3; a++) begin
        if (act_bits[a]) begin
          if ({1'b0, per_cnt[a]} + 17'd1 >= {1'b0, per_reload[a]}) begin
            per_cnt[a] = '0;
            if (scale_left[a] > 17'd1) begin
              scale_left[a] = scale_left[a] - 1;
            end else begin
              scale_left[a] = scale_reload[a];
              if (steps_rem[a] > 0) steps_rem[a] = steps_rem[a] - 1;
              if (steps_rem[a] == 0) begin
                act_bits[a] = 1'b0;
                en_bits[a] = 1'b0;
              end
              pulses[a] = 1'b1;
            end
          end else begin
            per_cnt[a] = per_cnt[a] + 1;
          end
        end
      end
    end else if (it.mode == qmsg_pkg::MODE_MOVE) begin
      if ((it.mx | it.my | it.mz) != 0 && ring_nx(wr_ptr) != rd_ptr) begin
        slot_mem[wr_ptr][0] = it.mx;
        slot_mem[wr_ptr][1] = it.my;
        slot_mem[wr_ptr][2] = it.mz;
        slot_mem[wr_ptr][3] = it.dur;
        wr_ptr = ring_nx(wr_ptr);
        acc = 1'b1;
      end
    end else if (it.mode == qmsg_pkg::MODE_FLUSH) begin
      rd_ptr = wr_ptr;
    end else begin
      rd_ptr = wr_ptr;
      act_bits = '0;
    end
    if (act_bits == 0 && wr_ptr != rd_ptr) begin
      tot = 64'(slot_mem[rd_ptr][3]) * 64'(tpu);
      for (int a = 0; a < 3; a++) begin
        raw = slot_mem[rd_ptr][a];
        neg = raw[31];
        mag = neg ? (32'd0 - raw) : raw;
        dir_bits[a] = neg ^ pol[a];
        if (mag != 0) begin
          per = tot / 64'(mag);
          if (per > 64'hFFFF_FFFF) per = 64'hFFFF_FFFF;
          scale = 17'd1;
          while ((per >> 16) != 0) begin
            per = per >> 1;
            scale = scale << 1;
          end
          if (per == 0) per = 1;
          steps_rem[a] = mag;
          scale_reload[a] = scale;
          scale_left[a] = scale;
          per_reload[a] = per[15:0];
          per_cnt[a] = '0;
          act_bits[a] = 1'b1;
          en_bits[a] = 1'b1;
        end
      end
      rd_ptr = ring_nx(rd_ptr);
    end
    r.step_pulse = pulses;
    r.direction = dir_bits;
    r.driver_enable = en_bits;
    r.active_mask = act_bits;
    r.queue_full = (ring_nx(wr_ptr) == rd_ptr);
    r.move_accepted = acc;
    r.queue_level = 2'((wr_ptr + 4 - rd_ptr) % 4);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sender
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_expected.push_back(motion_step(qmsg_pkg::item_t'{s_axis_tdata[1:0],
            s_axis_tdata[33:2], s_axis_tdata[65:34], s_axis_tdata[97:66],
            s_axis_tdata[129:98]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          qmsg_pkg::item_t w;
          w = pending_words.pop_front();
          s_axis_tdata <= {6'd0, w.dur, w.mz, w.my, w.mx, w.mode};
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int  sink_gap = 0;
  int  hold_cnt = 0;
  logic stall_seen = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_expected.size() == 0) begin
          report("unexpected word", m_axis_tdata, 0);
        end else begin
          qmsg_pkg::result_t e;
          e = status_expected.pop_front();
          if (m_axis_tdata[2:0] != e.step_pulse) report("step_pulse", m_axis_tdata[2:0], e.step_pulse);
          if (m_axis_tdata[5:3] != e.direction) report("direction", m_axis_tdata[5:3], e.direction);
          if (m_axis_tdata[8:6] != e.driver_enable)
            report("driver_enable", m_axis_tdata[8:6], e.driver_enable);
          if (m_axis_tdata[11:9] != e.active_mask)
            report("active_mask", m_axis_tdata[11:9], e.active_mask);
          if (m_axis_tdata[12] != e.queue_full) report("queue_full", m_axis_tdata[12], e.queue_full);
          if (m_axis_tdata[13] != e.move_accepted)
            report("move_accepted", m_axis_tdata[13], e.move_accepted);
          if (m_axis_tdata[15:14] != e.queue_level)
            report("queue_level", m_axis_tdata[15:14], e.queue_level);
        end
      end
      if (stall_req && !stall_seen) begin
        stall_seen <= 1'b1;
        hold_cnt <= 400;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 10);
      end
    end
  end

  // watchdog on handshake silence
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push(logic [1:0] m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [31:0] d);
    pending_words.push_back(qmsg_pkg::item_t'{m, x, y, z, d});
  endtask

  function automatic logic [31:0] small_delta();
    logic [31:0] v;
    v = $urandom_range(0, 4);
    if ($urandom_range(0, 1)) v = -v;
    return ($urandom_range(0, 3) == 0) ? 32'd0 : v;
  endfunction

  task automatic push_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) push(qmsg_pkg::MODE_TICK, $urandom, $urandom, $urandom, $urandom);
      else if (r < 86) push(qmsg_pkg::MODE_MOVE, small_delta(), small_delta(),
                            small_delta(), $urandom_range(0, 3));
      else if (r < 90) push(qmsg_pkg::MODE_MOVE, $urandom, $urandom, $urandom, $urandom);
      else if (r < 95) push(qmsg_pkg::MODE_FLUSH, $urandom, $urandom, $urandom, $urandom);
      else push(qmsg_pkg::MODE_KILL, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == qmsg_pkg::CFG_TPU) tpu = val;
    else pol = val[2:0];
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || status_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    wr_ptr = 0;
    rd_ptr = 0;
    for (int a = 0; a < 3; a++) begin
      steps_rem[a] = '0;
      scale_reload[a] = 17'd1;
      scale_left[a] = 17'd1;
      per_reload[a] = 16'd1;
      per_cnt[a] = '0;
    end
    act_bits = '0;
    dir_bits = '0;
    en_bits = '0;
    tpu = 8'd32;
    pol = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: zero move, zero duration, extremes, full queue, flush, kill
    push(qmsg_pkg::MODE_TICK, '0, '0, '0, '0);
    push(qmsg_pkg::MODE_MOVE, '0, '0, '0, 32'd5);
    push(qmsg_pkg::MODE_MOVE, 32'd1, '0, '0, '0);
    push(qmsg_pkg::MODE_TICK, '1, '1, '1, '1);
    push(qmsg_pkg::MODE_MOVE, 32'd2, -32'sd1, 32'd1, 32'd1);
    repeat (4) push(qmsg_pkg::MODE_TICK, '0, '0, '0, '0);
    push(qmsg_pkg::MODE_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(qmsg_pkg::MODE_MOVE, 32'd1, 32'd1, 32'd1, 32'd1);
    push(qmsg_pkg::MODE_MOVE, -32'sd1, '0, '0, 32'd2);
    push(qmsg_pkg::MODE_MOVE, '0, 32'd3, '0, 32'd3);
    push(qmsg_pkg::MODE_MOVE, '0, '0, 32'd4, 32'd4);
    push(qmsg_pkg::MODE_TICK, '0, '0, '0, '0);
    push(qmsg_pkg::MODE_FLUSH, '0, '0, '0, '0);
    push(qmsg_pkg::MODE_TICK, '0, '0, '0, '0);
    push(qmsg_pkg::MODE_KILL, '1, '1, '1, '1);
    push(qmsg_pkg::MODE_MOVE, 32'd1, '0, '0, 32'd1000);
    push(qmsg_pkg::MODE_TICK, '0, '0, '0, '0);
    push(qmsg_pkg::MODE_KILL, '0, '0, '0, '0);
    drain();

    cfg_write(qmsg_pkg::CFG_TPU, 8'd255);
    cfg_write(qmsg_pkg::CFG_POL, 8'hFF);
    push_random(150);
    drain();

    cfg_write(qmsg_pkg::CFG_TPU, 8'd1);
    cfg_write(qmsg_pkg::CFG_POL, 8'h00);
    push_random(180);
    drain();

    cfg_write(qmsg_pkg::CFG_TPU, 8'($urandom_range(1, 8)));
    cfg_write(qmsg_pkg::CFG_POL, 8'($urandom));
    push_random(150);
    stall_req = 1'b1;
    drain();

    calm = 1'b1;
    cfg_write(qmsg_pkg::CFG_TPU, 8'($urandom_range(1, 4)));
    cfg_write(qmsg_pkg::CFG_POL, 8'($urandom));
    push_random(150);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/qmsg_pkg.sv
sv/qmsg_div.sv
sv/qmsg_front.sv
sv/qmsg_back.sv
sv/queued_multi_axis_step_generator_core.sv
sv/qmsg_checker.sv
test/queued_multi_axis_step_generator_core_tb.sv
